>>> rtl/core/integer_clock_divider_planner_core_assert.svh
// Assertion helpers for the divider planner core
`ifndef INTEGER_CLOCK_DIVIDER_PLANNER_CORE_ASSERT_SVH
`define INTEGER_CLOCK_DIVIDER_PLANNER_CORE_ASSERT_SVH

// same-cycle implication
`define ICDP_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("icdp assertion failed");

// next-cycle implication
`define ICDP_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("icdp assertion failed");

`endif

>>> rtl/core/icdp_pkg.sv
package icdp_pkg;

    localparam int RefW   = 28;
    localparam int MultW  = 8;
    localparam int RegW   = 30;
    localparam int BaseW  = 22;
    localparam int OptW   = 12;
    localparam int Num2W  = 31;
    localparam int Den2W  = 19;

    localparam logic [1:0] REG_REF_MIN    = 2'd0;
    localparam logic [1:0] REG_REF_MAX    = 2'd1;
    localparam logic [1:0] REG_OUT_MAX    = 2'd2;
    localparam logic [1:0] REG_VCO_CENTER = 2'd3;

    localparam logic [29:0] RESET_REF_MIN    = 30'd10000000;
    localparam logic [29:0] RESET_REF_MAX    = 30'd40000000;
    localparam logic [29:0] RESET_OUT_MAX    = 30'd200000000;
    localparam logic [29:0] RESET_VCO_CENTER = 30'd750000000;

    localparam logic [17:0] P1_MAX    = 18'h3FFFF;
    localparam logic [15:0] RATIO_MAX = 16'hFFFF;
    localparam logic [1:0]  DIV4_ON   = 2'd3;

    // floor(2^32 / 100), used for the divide-by-100
    localparam logic [25:0] RECIP_100 = 26'd42949672;

    typedef struct packed {
        logic            reject;
        logic            bypass;
        logic            base_zero;
        logic [1:0]      code;
        logic [OptW-1:0] optim;
    } t_side;

    typedef struct packed {
        logic        ratio_invalid;
        logic        out_integer;
        logic [1:0]  div_by_four;
        logic [17:0] out_p1;
        logic [15:0] out_ratio;
        logic        fb_integer;
        logic [17:0] fb_p1;
        logic [15:0] fb_ratio;
        logic [3:0]  prediv;
        logic [1:0]  prediv_code;
        logic        bypass;
        logic        status;
    } t_result;

endpackage

>>> rtl/core/icdp_div.sv
// Restoring divider, one quotient bit per stage
module icdp_div
    import icdp_pkg::*;
#(
    parameter int NW = 30,
    parameter int DW = 22,
    parameter int PW = 8
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_en,
    input  logic          i_vld,
    input  logic [NW-1:0] i_num,
    input  logic [DW-1:0] i_den,
    input  logic [PW-1:0] i_pay,
    output logic          o_vld,
    output logic [NW-1:0] o_quo,
    output logic [PW-1:0] o_pay
);

    logic [DW-1:0] r_rem [NW];
    logic [NW-1:0] r_quo [NW];
    logic [DW-1:0] r_den [NW];
    logic [PW-1:0] r_pay [NW];
    logic          r_vld [NW];

    for (genvar s = 0; s < NW; s++) begin : g_stg
        logic [DW-1:0] rem_in;
        logic [NW-1:0] quo_in;
        logic [DW-1:0] den_in;
        logic [PW-1:0] pay_in;
        logic          vld_in;
        logic [DW:0]   trial;
        logic          take;

        if (s == 0) begin : g_first
            assign rem_in = '0;
            assign quo_in = i_num;
            assign den_in = i_den;
            assign pay_in = i_pay;
            assign vld_in = i_vld;
        end else begin : g_rest
            assign rem_in = r_rem[s-1];
            assign quo_in = r_quo[s-1];
            assign den_in = r_den[s-1];
            assign pay_in = r_pay[s-1];
            assign vld_in = r_vld[s-1];
        end

        assign trial = {rem_in, quo_in[NW-1]};
        assign take  = (trial >= {1'b0, den_in});

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[s] <= 1'b0;
            end else if (i_en) begin
                r_vld[s] <= vld_in;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[s] <= take ? DW'(trial - {1'b0, den_in}) : trial[DW-1:0];
                r_quo[s] <= {quo_in[NW-2:0], take};
                r_den[s] <= den_in;
                r_pay[s] <= pay_in;
            end
        end
    end

    assign o_vld = r_vld[NW-1];
    assign o_quo = r_quo[NW-1];
    assign o_pay = r_pay[NW-1];

endmodule

>>> rtl/core/icdp_front.sv
// Range checks, predivider choice, divided reference / 100
module icdp_front
    import icdp_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_en,
    input  logic             i_vld,
    input  logic [RefW-1:0]  i_ref,
    input  logic [MultW-1:0] i_mult,
    input  logic [RegW-1:0]  i_ref_min,
    input  logic [RegW-1:0]  i_ref_max,
    input  logic [RegW-1:0]  i_out_max,
    output logic             o_vld,
    output t_side            o_side,
    output logic [BaseW-1:0] o_base
);

    logic [35:0] prod;
    logic        ge1, ge2, ge4, rej;
    logic [1:0]  code;

    always_comb begin
        prod = i_ref * i_mult;
        rej  = (i_mult == '0) || ({2'b0, i_ref} < i_ref_min) || (prod > {6'b0, i_out_max});
        ge4  = {4'b0, i_ref} >= {i_ref_max, 2'b0};
        ge2  = {4'b0, i_ref} >= {1'b0, i_ref_max, 1'b0};
        ge1  = {4'b0, i_ref} >= {2'b0, i_ref_max};
        priority if (ge4) code = 2'd3;
        else if (ge2)     code = 2'd2;
        else if (ge1)     code = 2'd1;
        else              code = 2'd0;
    end

    // stage 1
    logic            r_vld1;
    t_side           r_side1;
    logic [RefW-1:0] r_x1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_vld1 <= 1'b0;
        else if (i_en) r_vld1 <= i_vld;
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_side1.reject    <= rej;
            r_side1.bypass    <= !rej && (i_mult == MultW'(1));
            r_side1.base_zero <= 1'b0;
            r_side1.code      <= code;
            r_side1.optim     <= {4'b0, i_mult} << ({1'b0, code} + 3'd1);
            r_x1              <= i_ref >> code;
        end
    end

    // stage 2: reciprocal estimate, low by at most one
    logic [53:0]      est;
    logic             r_vld2;
    t_side            r_side2;
    logic [RefW-1:0]  r_x2;
    logic [BaseW-1:0] r_q2;

    assign est = r_x1 * RECIP_100;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_vld2 <= 1'b0;
        else if (i_en) r_vld2 <= r_vld1;
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_side2 <= r_side1;
            r_x2    <= r_x1;
            r_q2    <= est[53:32];
        end
    end

    // stage 3: one-step correction
    logic [RefW-1:0]  rem;
    logic [BaseW-1:0] base;
    t_side            side3;
    logic             r_vld3;
    t_side            r_side3;
    logic [BaseW-1:0] r_base3;

    always_comb begin
        rem             = r_x2 - RefW'(r_q2) * RefW'(100);
        base            = r_q2 + BaseW'(rem >= RefW'(100));
        side3           = r_side2;
        side3.base_zero = (base == '0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_vld3 <= 1'b0;
        else if (i_en) r_vld3 <= r_vld2;
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_side3 <= side3;
            r_base3 <= base;
        end
    end

    assign o_vld  = r_vld3;
    assign o_side = r_side3;
    assign o_base = r_base3;

endmodule

>>> rtl/core/icdp_encode.sv
// Feedback ratio product, P1 encoding, saturation and flags
module icdp_encode
    import icdp_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_en,
    input  logic             i_vld,
    input  t_side            i_side,
    input  logic [Num2W-1:0] i_quo,
    output logic             o_vld,
    output t_result          o_res
);

    // stage E1
    logic                    r_vld1;
    t_side                   r_side1;
    logic [Num2W+OptW-1:0]   r_msn;
    logic [Num2W:0]          r_ms;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_vld1 <= 1'b0;
        else if (i_en) r_vld1 <= i_vld;
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_side1 <= i_side;
            r_msn   <= i_quo * i_side.optim;
            r_ms    <= {i_quo, 1'b0};
        end
    end

    // stage E2
    t_result     res;
    logic        bad;
    logic [10:0] fa, ma;

    always_comb begin
        res = '0;
        bad = 1'b0;
        fa  = r_msn[10:0] - 11'd4;
        ma  = r_ms[10:0] - 11'd4;
        if (r_side1.reject) begin
            res.status = 1'b1;
        end else if (r_side1.bypass) begin
            res.bypass = 1'b1;
            res.prediv = 4'd1;
        end else begin
            res.prediv_code = r_side1.code;
            res.prediv      = 4'd1 << r_side1.code;
            if (r_side1.base_zero) begin
                bad           = 1'b1;
                res.fb_ratio  = RATIO_MAX;
                res.fb_p1     = P1_MAX;
                res.out_ratio = RATIO_MAX;
                res.out_p1    = P1_MAX;
            end else begin
                if (r_msn < 43'd16 || r_msn > 43'd90) bad = 1'b1;
                res.fb_ratio = (r_msn > 43'(RATIO_MAX)) ? RATIO_MAX : r_msn[15:0];
                if (r_msn < 43'd4) begin
                    bad = 1'b1;
                end else if (r_msn > 43'd2051) begin
                    bad       = 1'b1;
                    res.fb_p1 = P1_MAX;
                end else begin
                    res.fb_p1 = {fa, 7'b0};
                end
                res.out_ratio = (r_ms > 32'(RATIO_MAX)) ? RATIO_MAX : r_ms[15:0];
                if (r_ms > 32'(RATIO_MAX)) bad = 1'b1;
                if (r_ms == 32'd4) begin
                    res.div_by_four = DIV4_ON;
                end else if (r_ms < 32'd4) begin
                    bad = 1'b1;
                end else if (r_ms > 32'd2051) begin
                    bad        = 1'b1;
                    res.out_p1 = P1_MAX;
                end else begin
                    res.out_p1 = {ma, 7'b0};
                end
            end
            res.fb_integer    = (res.fb_p1[7:0] == '0);
            res.out_integer   = (res.out_p1[7:0] == '0);
            res.ratio_invalid = bad;
        end
    end

    logic    r_vld2;
    t_result r_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_vld2 <= 1'b0;
        else if (i_en) r_vld2 <= r_vld1;
    end

    always_ff @(posedge i_clk) begin
        if (i_en) r_res <= res;
    end

    assign o_vld = r_vld2;
    assign o_res = r_res;

endmodule

>>> rtl/core/integer_clock_divider_planner_core.sv
// Channel   Dir  Width  Contents
// s_axis    in   40     ref_hz[27:0], multiplier[35:28]
// m_axis    out  88     one planned divider word per request
// cfg       in   30     write-only registers: ref_min, ref_max, out_max, vco_center
//
// The pipe has 3 front stages, 30 divider stages for vco/base, one numerator
// stage, 31 divider stages for the rounded ratio and 2 encode stages.
// One word per cycle unless stalled; the two bit-per-stage dividers set the depth only.
// Reset (sync, active low) clears valid bits and restores register defaults.
// A stall at the output freezes the whole pipe; nothing is dropped or repeated.
module integer_clock_divider_planner_core
    import icdp_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [39:0] i_s_tdata,   // ref_hz[27:0], multiplier[35:28], zero pad
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [87:0] o_m_tdata,   // status, bypass, prediv_code[1:0], prediv[3:0],
                                     // fb_ratio[15:0], fb_p1[17:0], fb_integer,
                                     // out_ratio[15:0], out_p1[17:0], div_by_four[1:0],
                                     // out_integer, ratio_invalid, zero pad
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_idx,
    input  logic [29:0] i_cfg_wdata
);

    // config registers
    logic [RegW-1:0] r_ref_min, r_ref_max, r_out_max, r_vco;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ref_min <= RESET_REF_MIN;
            r_ref_max <= RESET_REF_MAX;
            r_out_max <= RESET_OUT_MAX;
            r_vco     <= RESET_VCO_CENTER;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_REF_MIN:    r_ref_min <= i_cfg_wdata;
                REG_REF_MAX:    r_ref_max <= i_cfg_wdata;
                REG_OUT_MAX:    r_out_max <= i_cfg_wdata;
                REG_VCO_CENTER: r_vco     <= i_cfg_wdata;
                default:        r_ref_min <= r_ref_min;
            endcase
        end
    end

    // global advance: the output register frees up or is empty
    logic en;
    assign en         = !o_m_tvalid || i_m_tready;
    assign o_s_tready = en;

    logic             f_vld;
    t_side            f_side;
    logic [BaseW-1:0] f_base;

    icdp_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (en),
        .i_vld    (i_s_tvalid),
        .i_ref    (i_s_tdata[27:0]),
        .i_mult   (i_s_tdata[35:28]),
        .i_ref_min(r_ref_min),
        .i_ref_max(r_ref_max),
        .i_out_max(r_out_max),
        .o_vld    (f_vld),
        .o_side   (f_side),
        .o_base   (f_base)
    );

    // fbx100 = vco_center / base
    logic              d1_vld;
    logic [RegW-1:0]   d1_quo;
    logic [$bits(t_side)-1:0] d1_pay;
    t_side             d1_side;

    icdp_div #(.NW(RegW), .DW(BaseW), .PW($bits(t_side))) u_div_fb (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_en   (en),
        .i_vld  (f_vld),
        .i_num  (r_vco),
        .i_den  (f_base),
        .i_pay  (f_side),
        .o_vld  (d1_vld),
        .o_quo  (d1_quo),
        .o_pay  (d1_pay)
    );
    assign d1_side = t_side'(d1_pay);

    // rounded ratio operands: (fbx100 + optim*50) / (optim*100)
    logic             r_n_vld;
    t_side            r_n_side;
    logic [Num2W-1:0] r_num2;
    logic [Den2W-1:0] r_den2;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_n_vld <= 1'b0;
        else if (en) r_n_vld <= d1_vld;
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_n_side <= d1_side;
            r_num2   <= {1'b0, d1_quo} + Num2W'(d1_side.optim) * Num2W'(50);
            r_den2   <= Den2W'(d1_side.optim) * Den2W'(100);
        end
    end

    logic              d2_vld;
    logic [Num2W-1:0]  d2_quo;
    logic [$bits(t_side)-1:0] d2_pay;

    icdp_div #(.NW(Num2W), .DW(Den2W), .PW($bits(t_side))) u_div_rnd (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_en   (en),
        .i_vld  (r_n_vld),
        .i_num  (r_num2),
        .i_den  (r_den2),
        .i_pay  (r_n_side),
        .o_vld  (d2_vld),
        .o_quo  (d2_quo),
        .o_pay  (d2_pay)
    );

    t_result res;

    icdp_encode u_encode (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_en   (en),
        .i_vld  (d2_vld),
        .i_side (t_side'(d2_pay)),
        .i_quo  (d2_quo),
        .o_vld  (o_m_tvalid),
        .o_res  (res)
    );

    assign o_m_tdata = {7'b0, res};

`include "integer_clock_divider_planner_core_assert.svh"

    `ICDP_ASSERT_NOW(a_reject_clean, o_m_tvalid && res.status, !res.bypass && res.fb_ratio == '0 && res.prediv == '0)
    `ICDP_ASSERT_NOW(a_div4_p1, o_m_tvalid && res.div_by_four == DIV4_ON, res.out_p1 == '0 && res.out_ratio == 16'd4)
    `ICDP_ASSERT_NOW(a_sat_flag, o_m_tvalid && res.fb_ratio == RATIO_MAX, res.ratio_invalid)
    `ICDP_ASSERT_NEXT(a_stall_hold, o_m_tvalid && !i_m_tready, o_m_tvalid && $stable(res))

endmodule

>>> verif/tb_top.sv
module tb_top;
    import icdp_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    // Cycle budget: 1150 words with random idling and stalling, plus the pipe
    // latency per phase. This leaves a wide margin.
    localparam int CYCLE_LIMIT = 400000;
    localparam int DRAIN_CYCLES = 80;   // longer than the pipe latency
    localparam int REPORT_MAX = 10;

    typedef struct {
        logic [27:0] ref_hz;
        logic [7:0]  mult;
    } t_request;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_s_tvalid = 1'b0;
    logic        o_s_tready;
    logic [39:0] i_s_tdata = '0;
    logic        o_m_tvalid;
    logic        i_m_tready = 1'b0;
    logic [87:0] o_m_tdata;
    logic        i_cfg_we = 1'b0;
    logic [1:0]  i_cfg_idx = REG_REF_MIN;
    logic [29:0] i_cfg_wdata = '0;

    // shadow copy of the register file
    logic [29:0] ref_min_hz, ref_max_hz, out_max_hz, vco_center_hz;

    t_request pending_requests[$];
    t_result  planned_words[$];
    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int mismatch_count = 0;
    int cycle_count = 0;

    integer_clock_divider_planner_core dut (.*);

    always #1 i_clk = ~i_clk;

    // P1 = 128*a - 512, clamped at 0 and saturated at P1_MAX
    function automatic logic [17:0] encode_p1(longint unsigned a, inout bit bad);
        longint unsigned v;
        if (a < 4) begin
            bad = 1'b1;
            return '0;
        end
        if (a > (longint'(P1_MAX) + 512) / 128) begin
            bad = 1'b1;
            return P1_MAX;
        end
        v = 128 * a - 512;
        if (v > P1_MAX) begin
            bad = 1'b1;
            return P1_MAX;
        end
        return v[17:0];
    endfunction

    function automatic t_result plan_dividers(logic [27:0] ref_hz, logic [7:0] mult_in);
        longint unsigned r, m, q, dv, optim, base, fbx100, fb_a, out_a;
        logic [1:0] code;
        bit bad;
        t_result res;
        res = '0;
        bad = 1'b0;
        r = ref_hz;
        m = mult_in;
        if (m == 0 || r < ref_min_hz || r * m > out_max_hz) begin
            res.status = 1'b1;
            return res;
        end
        if (m == 1) begin
            res.bypass = 1'b1;
            res.prediv = 4'd1;
            return res;
        end
        q = (ref_max_hz == 0) ? 8 : r / ref_max_hz + 1;
        if (q > 4) begin
            dv = 8;
            code = 2'd3;
        end else if (q > 2) begin
            dv = 4;
            code = 2'd2;
        end else begin
            dv = q;
            code = q[1:0] - 2'd1;
        end
        optim = 2 * dv * m;
        base = (r / dv) / 100;
        if (base == 0) begin
            fb_a = 64'hFFFF_FFFF;   // slow divided reference: treat as saturated
        end else begin
            fbx100 = vco_center_hz / base;
            fb_a = optim * ((fbx100 + (optim / 2) * 100) / (optim * 100));
        end
        if (fb_a < 16 || fb_a > 90) bad = 1'b1;
        res.fb_p1 = encode_p1(fb_a, bad);
        out_a = fb_a / (m * dv);
        if (out_a == 4) begin
            res.out_p1 = '0;
            res.div_by_four = DIV4_ON;
        end else begin
            res.out_p1 = encode_p1(out_a, bad);
        end
        if (out_a > RATIO_MAX) bad = 1'b1;
        res.prediv_code = code;
        res.prediv = dv[3:0];
        res.fb_ratio = (fb_a > RATIO_MAX) ? RATIO_MAX : fb_a[15:0];
        res.fb_integer = (res.fb_p1[7:0] == 8'd0);
        res.out_ratio = (out_a > RATIO_MAX) ? RATIO_MAX : out_a[15:0];
        res.out_integer = (res.out_p1[7:0] == 8'd0);
        res.ratio_invalid = bad;
        return res;
    endfunction

    // Driver: an accepted word is predicted at the edge it is taken,
    // then the next one is loaded (or valid drops) with a single assignment.
    always @(posedge i_clk) begin
        t_request req;
        if (!i_rst_n) begin
            i_s_tvalid <= 1'b0;
        end else begin
            if (i_s_tvalid && o_s_tready)
                planned_words.push_back(plan_dividers(i_s_tdata[27:0], i_s_tdata[35:28]));
            if (!i_s_tvalid || o_s_tready) begin
                if (pending_requests.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
                    req = pending_requests.pop_front();
                    i_s_tdata <= {4'b0, req.mult, req.ref_hz};
                    i_s_tvalid <= 1'b1;
                end else begin
                    i_s_tvalid <= 1'b0;
                end
            end
        end
    end

    // Monitor: checks each accepted word against the oldest plan, then
    // picks the ready level for the next edge.
    always @(posedge i_clk) begin
        t_result got, want;
        bit bad;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            got = t_result'(o_m_tdata[$bits(t_result)-1:0]);
            if (planned_words.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= REPORT_MAX)
                    $display("unexpected word: %p", got);
            end else begin
                want = planned_words.pop_front();
                bad = (got.status != want.status) || (got.bypass != want.bypass)
                    || (got.prediv_code != want.prediv_code) || (got.prediv != want.prediv)
                    || (got.fb_ratio != want.fb_ratio) || (got.fb_p1 != want.fb_p1)
                    || (got.fb_integer != want.fb_integer)
                    || (got.out_ratio != want.out_ratio) || (got.out_p1 != want.out_p1)
                    || (got.div_by_four != want.div_by_four)
                    || (got.out_integer != want.out_integer)
                    || (got.ratio_invalid != want.ratio_invalid)
                    || (o_m_tdata[87:$bits(t_result)] != '0);
                if (bad) begin
                    mismatch_count++;
                    if (mismatch_count <= REPORT_MAX)
                        $display("word mismatch: expected %p actual %p", want, got);
                end
            end
        end
        i_m_tready <= i_rst_n && ($urandom_range(99) >= recv_stall_pct);
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("integer_clock_divider_planner_core regression: fail");
            $finish;
        end
    end

    task automatic write_reg(logic [1:0] idx, logic [29:0] value);
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_wdata <= value;
        case (idx)
            REG_REF_MIN:    ref_min_hz = value;
            REG_REF_MAX:    ref_max_hz = value;
            REG_OUT_MAX:    out_max_hz = value;
            default:        vco_center_hz = value;
        endcase
    endtask

    task automatic load_regs(int rmin, int rmax, int omax, int vco);
        write_reg(REG_REF_MIN, 30'(rmin));
        write_reg(REG_REF_MAX, 30'(rmax));
        write_reg(REG_OUT_MAX, 30'(omax));
        write_reg(REG_VCO_CENTER, 30'(vco));
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic add_request(longint unsigned r, longint unsigned m);
        t_request req;
        req.ref_hz = r[27:0];
        req.mult = m[7:0];
        pending_requests.push_back(req);
    endtask

    // Mostly legal requests (in range, product fits) so the planner runs;
    // the rest are raw random words that mostly get rejected.
    task automatic add_random(int count);
        longint unsigned m, lo, hi;
        repeat (count) begin
            if ($urandom_range(99) < 25) begin
                add_request($urandom_range(28'hFFFFFFF), $urandom_range(255));
            end else begin
                m = ($urandom_range(1) == 1) ? $urandom_range(2, 12) : $urandom_range(1, 255);
                hi = (m == 0) ? 0 : out_max_hz / m;
                if (hi > 28'hFFFFFFF) hi = 28'hFFFFFFF;
                lo = (ref_min_hz < hi) ? ref_min_hz : hi;
                add_request($urandom_range(hi, lo), m);
            end
        end
    endtask

    task automatic drain;
        wait (pending_requests.size() == 0 && planned_words.size() == 0 && !i_s_tvalid);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    initial begin
        ref_min_hz = RESET_REF_MIN;
        ref_max_hz = RESET_REF_MAX;
        out_max_hz = RESET_OUT_MAX;
        vco_center_hz = RESET_VCO_CENTER;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed, reset registers: rejects, bypass, predividers 1, 2 and 4
        add_request(27000000, 0);              // zero multiplier
        add_request(9999999, 4);               // reference below minimum
        add_request(28'hFFFFFFF, 8'hFF);       // product too large, all ones
        add_request(0, 0);
        add_request(27000000, 1);              // bypass
        add_request(10000000, 20);             // product at the upper bound
        add_request(25000000, 2);
        add_request(27000000, 7);
        add_request(50000000, 3);              // predivide by 2
        add_request(100000000, 2);             // predivide by 4
        add_request(200000000, 1);
        add_request(199999999, 1);
        add_request(37500000, 2);              // lands on output ratio 10
        add_request(40000000, 5);
        add_request(12000000, 16);
        drain();

        // Phase 1: defaults, no idling; part sent, pause until empty, rest sent
        add_random(100);
        drain();
        add_random(100);
        drain();

        // Phase 2: tiny ref_max forces divide-by-8 from 4 Hz up; slow reference saturates
        load_regs(0, 1, 1000000000, 1000000000);
        add_request(0, 2);
        add_request(799, 2);                   // divided reference under 100 Hz
        add_request(800, 255);
        add_request(268435455, 3);             // predivide by 8, large reference
        send_idle_pct = 63;
        add_random(220);
        drain();

        // Phase 3: huge ref_max, zero VCO target (negative P1 clamp)
        load_regs(1000, 1000000000, 1000000000, 0);
        add_request(5000000, 2);
        send_idle_pct = 0;
        recv_stall_pct = 63;
        add_random(220);
        drain();

        // Phase 4: mid settings, both sides busy
        load_regs(0, 5000000, 1000000000, 500000000);
        send_idle_pct = 38;
        recv_stall_pct = 38;
        add_random(220);
        drain();

        // Phase 5: everything rejected with no idling, then mixed with both sides busy
        load_regs(1000000000, 1000000000, 0, 750000000);
        send_idle_pct = 0;
        recv_stall_pct = 0;
        add_random(30);
        drain();
        load_regs(1000000, 25000000, 900000000, 900000000);
        send_idle_pct = 63;
        recv_stall_pct = 63;
        add_random(240);
        drain();

        if (mismatch_count == 0) begin
            $display("integer_clock_divider_planner_core regression: pass");
        end else begin
            $display("integer_clock_divider_planner_core regression: fail");
        end
        $finish;
    end

endmodule
